FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/legv8_pkg.sv
// Types, constants and a helper function of the LEGv8 execute unit.
package legv8_pkg;

    localparam int STACK_BYTES = 512;
    localparam int MAIN_BYTES  = 4096;
    localparam int NUM_REGS    = 32;

    localparam int STACK_AW = $clog2(STACK_BYTES);
    localparam int MAIN_AW  = $clog2(MAIN_BYTES);
    localparam int MEM_AW   = (STACK_AW > MAIN_AW) ? STACK_AW : MAIN_AW;
    localparam int REG_AW   = $clog2(NUM_REGS);

    localparam int IN_W  = 144;
    localparam int OUT_W = 152;
    localparam int FLAG_W = 14;

    localparam logic [7:0] BYTE_MASK = 8'hff;
    localparam logic [3:0] WORD_BYTES = 4'd8;
    localparam logic [2:0] LAST_BYTE = 3'd7;

    localparam logic [REG_AW-1:0] REG_SP   = 5'd28;
    localparam logic [REG_AW-1:0] REG_FP   = 5'd29;
    localparam logic [REG_AW-1:0] REG_LINK = 5'd30;
    localparam logic [REG_AW-1:0] REG_ZERO = 5'd31;

    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_AND   = 5'd1;
    localparam logic [4:0] OP_EOR   = 5'd2;
    localparam logic [4:0] OP_ORR   = 5'd3;
    localparam logic [4:0] OP_SUB   = 5'd4;
    localparam logic [4:0] OP_UDIV  = 5'd5;
    localparam logic [4:0] OP_BR    = 5'd6;
    localparam logic [4:0] OP_SUBS  = 5'd7;
    localparam logic [4:0] OP_LSL   = 5'd8;
    localparam logic [4:0] OP_LSR   = 5'd9;
    localparam logic [4:0] OP_MUL   = 5'd10;
    localparam logic [4:0] OP_ADDI  = 5'd11;
    localparam logic [4:0] OP_ANDI  = 5'd12;
    localparam logic [4:0] OP_EORI  = 5'd13;
    localparam logic [4:0] OP_ORRI  = 5'd14;
    localparam logic [4:0] OP_SUBI  = 5'd15;
    localparam logic [4:0] OP_SUBIS = 5'd16;
    localparam logic [4:0] OP_B     = 5'd17;
    localparam logic [4:0] OP_BL    = 5'd18;
    localparam logic [4:0] OP_BCOND = 5'd19;
    localparam logic [4:0] OP_CBNZ  = 5'd20;
    localparam logic [4:0] OP_CBZ   = 5'd21;
    localparam logic [4:0] OP_LDUR  = 5'd22;
    localparam logic [4:0] OP_STUR  = 5'd23;

    localparam logic [4:0] COND_COUNT = 5'd14;

    typedef struct packed {
        logic [4:0]        op;
        logic [63:0]       pc;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [REG_AW-1:0] widx;
        logic              wr;
        logic [4:0]        rt;
        logic [5:0]        shamt;
        logic [11:0]       imm;
        logic [25:0]       boff;
        logic [8:0]        moff;
    } uop_t;

    // flags from the sign and zero test of a 32-bit difference
    function automatic logic [FLAG_W-1:0] sub_flags(input logic [31:0] d);
        logic neg;
        logic zero;
        logic [FLAG_W-1:0] f;
        neg  = d[31];
        zero = (d == 32'd0);
        f = '0;
        f[0]  = zero;
        f[1]  = !zero;
        f[2]  = !neg;
        f[5]  = !neg;
        f[10] = !neg;
        f[8]  = !neg && !zero;
        f[12] = !neg && !zero;
        f[9]  = neg || zero;
        f[13] = neg || zero;
        f[3]  = neg;
        f[4]  = neg;
        f[11] = neg;
        return f;
    endfunction

endpackage

FILE: sv/legv8_front.sv
// Front end: accepts instruction words, decodes register use, queues them.
module legv8_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op, pc, rd, rn, rm, rt, shamt, alu_imm, branch_offset, mem_offset (low bit up)
    input  logic [legv8_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                      hold,
    output logic                      q_valid,
    output legv8_pkg::uop_t           q_data,
    input  logic                      q_pop
);

    legv8_pkg::uop_t q_mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    legv8_pkg::uop_t dec;
    logic [4:0] f_rd, f_rm;
    logic push;

    always_comb
    begin
        dec.op    = s_axis_tdata[4:0];
        dec.pc    = s_axis_tdata[68:5];
        f_rd      = s_axis_tdata[73:69];
        dec.ra    = s_axis_tdata[78:74];
        f_rm      = s_axis_tdata[83:79];
        dec.rt    = s_axis_tdata[88:84];
        dec.shamt = s_axis_tdata[94:89];
        dec.imm   = s_axis_tdata[106:95];
        dec.boff  = s_axis_tdata[132:107];
        dec.moff  = s_axis_tdata[141:133];

        if (dec.op == legv8_pkg::OP_BR)
            dec.rb = f_rd;
        else if (dec.op inside {legv8_pkg::OP_CBNZ, legv8_pkg::OP_CBZ, legv8_pkg::OP_STUR})
            dec.rb = dec.rt;
        else
            dec.rb = f_rm;

        if (dec.op == legv8_pkg::OP_BL)
            dec.widx = legv8_pkg::REG_LINK;
        else if (dec.op == legv8_pkg::OP_LDUR)
            dec.widx = dec.rt;
        else
            dec.widx = f_rd;

        dec.wr = (dec.op inside {[legv8_pkg::OP_ADD : legv8_pkg::OP_UDIV],
                                 [legv8_pkg::OP_SUBS : legv8_pkg::OP_SUBIS],
                                 legv8_pkg::OP_BL, legv8_pkg::OP_LDUR})
                 && (dec.widx != legv8_pkg::REG_ZERO);
    end

    assign s_axis_tready = (cnt_reg != 2'd2) && !hold;
    assign push    = s_axis_tvalid && s_axis_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/legv8_div.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
module legv8_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] d_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] shifted;
    logic [64:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[63]};
        diff      = shifted - {1'b0, d_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            q_next    = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[64])
            begin
                rem_next = diff[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            d_reg <= divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: sv/legv8_back.sv
// Back end: register file, flags, memories and the sequencer that runs each op.
module legv8_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  legv8_pkg::uop_t             q_data,
    output logic                        q_pop,
    output logic                        clearing,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // next_pc, reg_written, write_index, write_value, flag_bits (low bit up)
    output logic [legv8_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int AW  = legv8_pkg::MEM_AW;
    localparam int SAW = legv8_pkg::STACK_AW;
    localparam int MAW = legv8_pkg::MAIN_AW;

    logic [2:0] state_reg;
    legv8_pkg::uop_t u_reg;
    logic [63:0] a_reg, b_reg;
    logic [63:0] rf [legv8_pkg::NUM_REGS];
    logic [legv8_pkg::NUM_REGS-1:0] rf_valid_reg;
    logic [legv8_pkg::FLAG_W-1:0] flags_reg;
    logic [63:0] val_reg, pc_out_reg, acc_reg;
    logic [1:0]  mcnt_reg;
    logic [3:0]  cnt_reg;
    logic [AW-1:0] addr_reg, clr_cnt_reg;
    logic        is_stack_reg;
    logic        clr_reg;
    logic [63:0] sv_reg;
    logic        out_valid_reg;
    logic [legv8_pkg::OUT_W-1:0] out_data_reg;

    logic [7:0] stack_mem [legv8_pkg::STACK_BYTES];
    logic [7:0] heap_mem  [legv8_pkg::MAIN_BYTES];
    logic [7:0] st_rd_reg, mn_rd_reg;

    logic [AW-1:0] mem_a;
    logic          st_we, mn_we;
    logic [7:0]    wd;
    logic [7:0]    rd_byte;
    logic [63:0]   target;
    logic [31:0]   d32;
    logic [31:0]   mul_x, mul_y;
    logic [63:0]   prod, prod_sh;
    logic          div_start, div_done;
    logic [63:0]   div_q;
    logic          out_free;
    logic          wr_fin;
    logic [63:0]   val_exec, pc_exec;

    assign mem_a    = addr_reg + AW'(cnt_reg[2:0]);
    assign rd_byte  = is_stack_reg ? st_rd_reg : mn_rd_reg;
    assign target   = u_reg.pc + {{36{u_reg.boff[25]}}, u_reg.boff, 2'b00};
    assign out_free = !out_valid_reg || m_axis_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && !clr_reg;
    assign clearing = clr_reg;
    assign wr_fin   = u_reg.wr;

    // store path and clearing pass share one write port per memory
    always_comb
    begin
        wd    = clr_reg ? 8'd0 : (sv_reg[63:56] & legv8_pkg::BYTE_MASK);
        st_we = clr_reg || ((state_reg == S_MEM) && (u_reg.op == legv8_pkg::OP_STUR)
                            && is_stack_reg);
        mn_we = clr_reg || ((state_reg == S_MEM) && (u_reg.op == legv8_pkg::OP_STUR)
                            && !is_stack_reg);
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[clr_reg ? clr_cnt_reg[SAW-1:0] : mem_a[SAW-1:0]] <= wd;
        st_rd_reg <= stack_mem[mem_a[SAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (mn_we)
            heap_mem[clr_reg ? clr_cnt_reg[MAW-1:0] : mem_a[MAW-1:0]] <= wd;
        mn_rd_reg <= heap_mem[mem_a[MAW-1:0]];
    end

    // one 32x32 partial product per cycle, low 64 bits of the full product
    always_comb
    begin
        case (mcnt_reg)
            2'd0:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
        endcase
        prod    = {32'd0, mul_x} * {32'd0, mul_y};
        prod_sh = (mcnt_reg == 2'd0) ? prod : {prod[31:0], 32'd0};
    end

    assign d32 = a_reg[31:0] - ((u_reg.op == legv8_pkg::OP_SUBIS) ?
                                {20'd0, u_reg.imm} : b_reg[31:0]);
    assign div_start = (state_reg == S_EXEC) && (u_reg.op == legv8_pkg::OP_UDIV)
                       && (b_reg != 64'd0);

    legv8_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ALU, compare and branch ops: value and next pc
    always_comb
    begin
        val_exec = 64'd0;
        pc_exec  = u_reg.pc;
        case (u_reg.op)
            legv8_pkg::OP_ADD:   val_exec = a_reg + b_reg;
            legv8_pkg::OP_AND:   val_exec = a_reg & b_reg;
            legv8_pkg::OP_EOR:   val_exec = a_reg ^ b_reg;
            legv8_pkg::OP_ORR:   val_exec = a_reg | b_reg;
            legv8_pkg::OP_SUB:   val_exec = a_reg - b_reg;
            legv8_pkg::OP_LSL:   val_exec = a_reg << u_reg.shamt;
            legv8_pkg::OP_LSR:   val_exec = a_reg >> u_reg.shamt;
            legv8_pkg::OP_ADDI:  val_exec = a_reg + {52'd0, u_reg.imm};
            legv8_pkg::OP_ANDI:  val_exec = a_reg & {52'd0, u_reg.imm};
            legv8_pkg::OP_EORI:  val_exec = a_reg ^ {52'd0, u_reg.imm};
            legv8_pkg::OP_ORRI:  val_exec = a_reg | {52'd0, u_reg.imm};
            legv8_pkg::OP_SUBI:  val_exec = a_reg - {52'd0, u_reg.imm};
            legv8_pkg::OP_SUBS,
            legv8_pkg::OP_SUBIS: val_exec = {{32{d32[31]}}, d32};
            legv8_pkg::OP_BR:    pc_exec = b_reg;
            legv8_pkg::OP_B:     pc_exec = target;
            legv8_pkg::OP_BL:
            begin
                pc_exec  = target;
                val_exec = u_reg.pc + 64'd4;
            end
            legv8_pkg::OP_BCOND:
                if (u_reg.rt < legv8_pkg::COND_COUNT && flags_reg[u_reg.rt[3:0]])
                    pc_exec = target;
            legv8_pkg::OP_CBNZ:
                if (b_reg != 64'd0)
                    pc_exec = target;
            legv8_pkg::OP_CBZ:
                if (b_reg == 64'd0)
                    pc_exec = target;
            default: ;
        endcase
    end

    // register file data and the popped op with its operands, no reset
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            u_reg <= q_data;
            a_reg <= (rf_valid_reg[q_data.ra] && q_data.ra != legv8_pkg::REG_ZERO) ?
                     rf[q_data.ra] : 64'd0;
            b_reg <= (rf_valid_reg[q_data.rb] && q_data.rb != legv8_pkg::REG_ZERO) ?
                     rf[q_data.rb] : 64'd0;
        end
        if ((state_reg == S_OUT) && out_free && wr_fin)
            rf[u_reg.widx] <= val_reg;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_EXEC:
            begin
                pc_out_reg <= pc_exec;
                val_reg    <= val_exec;
                acc_reg    <= 64'd0;
                addr_reg   <= AW'(a_reg + {{55{u_reg.moff[8]}}, u_reg.moff});
                is_stack_reg <= (u_reg.ra == legv8_pkg::REG_SP) ||
                                (u_reg.ra == legv8_pkg::REG_FP);
                sv_reg     <= b_reg;
            end
            S_MUL:
            begin
                acc_reg <= acc_reg + prod_sh;
                val_reg <= acc_reg + prod_sh;
            end
            S_DIV:
                if (div_done)
                    val_reg <= div_q;
            S_MEM:
            begin
                // read data comes from a registered read of the previous address
                if (cnt_reg != 4'd0)
                    val_reg <= {val_reg[55:0], rd_byte};
                sv_reg <= {sv_reg[55:0], 8'd0};
            end
            default: ;
        endcase
        if ((state_reg == S_OUT) && out_free)
            out_data_reg <= {4'd0, flags_reg,
                             wr_fin ? val_reg : 64'd0,
                             wr_fin ? u_reg.widx : 5'd0,
                             wr_fin, pc_out_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rf_valid_reg  <= '0;
            flags_reg     <= '0;
            mcnt_reg      <= 2'd0;
            cnt_reg       <= 4'd0;
            clr_reg       <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == {AW{1'b1}})
                    clr_reg <= 1'b0;
            end
            if ((state_reg == S_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (q_pop)
                        state_reg <= S_EXEC;
                S_EXEC:
                begin
                    mcnt_reg <= 2'd0;
                    cnt_reg  <= 4'd0;
                    case (u_reg.op)
                        legv8_pkg::OP_MUL:  state_reg <= S_MUL;
                        legv8_pkg::OP_UDIV: state_reg <= (b_reg == 64'd0) ? S_OUT : S_DIV;
                        legv8_pkg::OP_LDUR,
                        legv8_pkg::OP_STUR: state_reg <= S_MEM;
                        legv8_pkg::OP_SUBS,
                        legv8_pkg::OP_SUBIS:
                        begin
                            flags_reg <= legv8_pkg::sub_flags(d32);
                            state_reg <= S_OUT;
                        end
                        default:            state_reg <= S_OUT;
                    endcase
                end
                S_MUL:
                begin
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd2)
                        state_reg <= S_OUT;
                end
                S_DIV:
                    if (div_done)
                        state_reg <= S_OUT;
                S_MEM:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (u_reg.op == legv8_pkg::OP_STUR)
                    begin
                        if (cnt_reg[2:0] == legv8_pkg::LAST_BYTE)
                            state_reg <= S_OUT;
                    end
                    else if (cnt_reg == legv8_pkg::WORD_BYTES)
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_free)
                    begin
                        if (wr_fin)
                            rf_valid_reg[u_reg.widx] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: sv/legv8_integer_execute_top.sv
// From accept to result valid, ALU ops, branches and UDIV by zero pass execute and output;
// MUL adds partial products, STUR and LDUR move one byte per cycle, UDIV one bit per cycle.
// One instruction executes at a time; a two-entry queue takes the next words meanwhile, and
// a stalled output holds the back end until it drains. After reset the memories are swept
// to zero with no word accepted; the register file and flags read as zero at once.
`include "assert_macros.svh"

module legv8_integer_execute_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // op, pc, rd, rn, rm, rt, shamt, alu_imm, branch_offset, mem_offset (low bit up)
    input  logic [legv8_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // next_pc, reg_written, write_index, write_value, flag_bits (low bit up)
    output logic [legv8_pkg::OUT_W-1:0] m_axis_tdata
);

    logic            q_valid;
    legv8_pkg::uop_t q_data;
    logic            q_pop;
    logic            clearing;
    logic            out_wr;
    logic [4:0]      out_widx;
    logic [63:0]     out_val;

    assign out_wr   = m_axis_tdata[64];
    assign out_widx = m_axis_tdata[69:65];
    assign out_val  = m_axis_tdata[133:70];

    legv8_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .hold          (clearing),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop)
    );

    legv8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_IMPLIES(a_no_accept_clr, clk, rst_n, clearing, !s_axis_tready)
    `ASSERT_NEXT(a_clr_once, clk, rst_n, !clearing, !clearing)
    `ASSERT_IMPLIES(a_nowrite_zero, clk, rst_n, m_axis_tvalid && !out_wr, (out_widx == 5'd0) && (out_val == 64'd0))
    `ASSERT_IMPLIES(a_no_xzr_write, clk, rst_n, m_axis_tvalid && out_wr, out_widx != legv8_pkg::REG_ZERO)

endmodule
